>>> src/opt_pkg.sv
// ----------------------------------------------------------------------------
// Online perceptron trainer package
// Shared widths, function codes and the queue item passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package opt_pkg;

   localparam int DIM_DEFAULT = 8;
   localparam int QUEUE_DEPTH = 4;

   localparam int FUNC_W   = 2;
   localparam int FEAT_W   = 16;
   localparam int WEIGHT_W = 32;
   localparam int PROD_W   = 48;
   localparam int ACC_W    = 56;
   localparam int DELTA_W  = 20;
   localparam int COUNT_W  = 32;
   localparam int BIAS_SHIFT = 14;

   localparam logic [FUNC_W-1:0] FUNC_PREDICT    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PERCEPTRON = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DELTA      = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic signed [FEAT_W-1:0] feature;
      logic                     label;
      logic                     last;
   } queue_item_type;

endpackage

`default_nettype wire

>>> src/opt_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts feature words, tags the last feature of each sample and pushes them
// into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module opt_front #(
   parameter int DIM = opt_pkg::DIM_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [opt_pkg::FUNC_W-1:0]    req_func,
   input  wire logic signed [opt_pkg::FEAT_W-1:0] req_feature,
   input  wire logic                          req_label,
   input  wire logic                          q_full,
   output logic                               q_push,
   output opt_pkg::queue_item_type            q_item
);
   import opt_pkg::*;

   localparam int IDX_W = (DIM > 1) ? $clog2(DIM) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);

   logic [IDX_W-1:0] pos_ff;
   logic [IDX_W-1:0] pos_in;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   assign q_item.func    = req_func;
   assign q_item.feature = req_feature;
   assign q_item.label   = req_label;
   assign q_item.last    = (pos_ff == LAST_IDX);

   always_comb begin
      pos_in = pos_ff;
      if (q_push) begin
         pos_in = (pos_ff == LAST_IDX) ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

`default_nettype wire

>>> src/opt_queue.sv
// ----------------------------------------------------------------------------
// Item queue
// Small first-in first-out buffer between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module opt_queue #(
   parameter int DEPTH = opt_pkg::QUEUE_DEPTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire opt_pkg::queue_item_type push_item,
   output logic                         full,
   input  wire logic                    pop,
   output opt_pkg::queue_item_type      pop_item,
   output logic                         empty
);
   import opt_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   queue_item_type   slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> src/opt_back.sv
// ----------------------------------------------------------------------------
// Back end
// Accumulates the dot product, predicts, walks the weights on an update and
// holds the result word in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module opt_back #(
   parameter int DIM = opt_pkg::DIM_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire opt_pkg::queue_item_type       q_item,
   input  wire logic                          q_empty,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_predicted_class,
   output logic                               rsp_misclassified,
   output logic                               rsp_weights_changed,
   output logic [opt_pkg::COUNT_W-1:0]        rsp_update_count
);
   import opt_pkg::*;

   localparam int IDX_W = (DIM > 1) ? $clog2(DIM) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);
   localparam logic signed [FEAT_W-1:0] Q14_ONE = FEAT_W'(16384);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_MUL    = 8'b0000_0010,
      ST_ACC    = 8'b0000_0100,
      ST_DECIDE = 8'b0000_1000,
      ST_UPD_RD = 8'b0001_0000,
      ST_UPD_WR = 8'b0010_0000,
      ST_BIAS   = 8'b0100_0000,
      ST_EMIT   = 8'b1000_0000
   } state_type;

   // Step is the feature times +/-1, or times +/-4 for the delta rule.
   function automatic logic signed [DELTA_W-1:0] step_delta(
      input logic signed [FEAT_W-1:0] x,
      input logic                     neg,
      input logic                     quad
   );
      logic signed [DELTA_W-1:0] mag;
      mag = {{(DELTA_W-FEAT_W){x[FEAT_W-1]}}, x};
      if (quad) begin
         mag = mag <<< 2;
      end
      return neg ? -mag : mag;
   endfunction

   function automatic logic signed [WEIGHT_W-1:0] sat_add(
      input logic signed [WEIGHT_W-1:0] w,
      input logic signed [DELTA_W-1:0]  d
   );
      logic signed [WEIGHT_W:0] s;
      s = {w[WEIGHT_W-1], w} + {{(WEIGHT_W+1-DELTA_W){d[DELTA_W-1]}}, d};
      if (s[WEIGHT_W] != s[WEIGHT_W-1]) begin
         return s[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}} : {1'b0, {(WEIGHT_W-1){1'b1}}};
      end
      return s[WEIGHT_W-1:0];
   endfunction

   state_type state_ff, state_in;

   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [IDX_W-1:0]           walk_ff, walk_in;
   logic signed [FEAT_W-1:0]   x_ff, x_in;
   logic [FUNC_W-1:0]          func_ff, func_in;
   logic                       label_ff, label_in;
   logic                       last_ff, last_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [WEIGHT_W-1:0] bias_ff, bias_in;
   logic                       pred_neg_ff, pred_neg_in;
   logic                       mis_ff, mis_in;
   logic                       changed_ff, changed_in;
   logic [COUNT_W-1:0]         cnt_ff, cnt_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_pred_ff, rsp_pred_in;
   logic                       rsp_mis_ff, rsp_mis_in;
   logic                       rsp_chg_ff, rsp_chg_in;
   logic [COUNT_W-1:0]         rsp_cnt_ff, rsp_cnt_in;

   // Weight and feature stores with registered reads.
   logic signed [WEIGHT_W-1:0] wmem [DIM];
   logic signed [FEAT_W-1:0]   fmem [DIM];
   logic [DIM-1:0]             wval_ff, wval_in;
   logic signed [WEIGHT_W-1:0] wrd_ff;
   logic                       wvld_ff;
   logic signed [FEAT_W-1:0]   frd_ff;

   logic [IDX_W-1:0]           rd_addr;
   logic signed [WEIGHT_W-1:0] weight_rd;
   logic                       w_we;
   logic signed [WEIGHT_W-1:0] w_wdata;
   logic                       quad;
   logic signed [ACC_W-1:0]    z;
   logic                       do_update;
   logic                       out_free;

   assign rd_addr   = (state_ff == ST_UPD_RD) ? walk_ff : idx_ff;
   assign weight_rd = wvld_ff ? wrd_ff : '0;
   assign quad      = (func_ff == FUNC_DELTA);
   assign z         = acc_ff + (ACC_W'(bias_ff) <<< BIAS_SHIFT);
   assign do_update = (z[ACC_W-1] != label_ff)
                      && (func_ff == FUNC_PERCEPTRON || func_ff == FUNC_DELTA);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign w_we      = (state_ff == ST_UPD_WR);
   assign w_wdata   = sat_add(weight_rd, step_delta(frd_ff, label_ff, quad));

   // The next feature may be taken while the previous product is summed.
   assign q_pop = !q_empty && ((state_ff == ST_IDLE) || (state_ff == ST_ACC && !last_ff));

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      walk_in     = walk_ff;
      x_in        = x_ff;
      func_in     = func_ff;
      label_in    = label_ff;
      last_in     = last_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      bias_in     = bias_ff;
      pred_neg_in = pred_neg_ff;
      mis_in      = mis_ff;
      changed_in  = changed_ff;
      cnt_in      = cnt_ff;
      wval_in     = wval_ff;
      rsp_pred_in = rsp_pred_ff;
      rsp_mis_in  = rsp_mis_ff;
      rsp_chg_in  = rsp_chg_ff;
      rsp_cnt_in  = rsp_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (q_pop) begin
         x_in     = q_item.feature;
         func_in  = q_item.func;
         label_in = q_item.label;
         last_in  = q_item.last;
         idx_in   = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
      end

      if (w_we) begin
         wval_in[walk_ff] = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(weight_rd) * PROD_W'(x_ff);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
            if (last_ff) begin
               state_in = ST_DECIDE;
            end else if (q_pop) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DECIDE: begin
            pred_neg_in = z[ACC_W-1];
            mis_in      = (z[ACC_W-1] != label_ff);
            changed_in  = do_update;
            walk_in     = '0;
            state_in    = do_update ? ST_UPD_RD : ST_EMIT;
         end
         ST_UPD_RD: begin
            state_in = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            if (walk_ff == LAST_IDX) begin
               state_in = ST_BIAS;
            end else begin
               walk_in  = walk_ff + 1'b1;
               state_in = ST_UPD_RD;
            end
         end
         ST_BIAS: begin
            bias_in  = sat_add(bias_ff, step_delta(Q14_ONE, label_ff, quad));
            cnt_in   = (cnt_ff == '1) ? cnt_ff : cnt_ff + 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pred_in  = pred_neg_ff;
               rsp_mis_in   = mis_ff;
               rsp_chg_in   = changed_ff;
               rsp_cnt_in   = cnt_ff;
               acc_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         wmem[walk_ff] <= w_wdata;
      end
      if (q_pop) begin
         fmem[idx_ff] <= q_item.feature;
      end
      wrd_ff  <= wmem[rd_addr];
      wvld_ff <= wval_ff[rd_addr];
      frd_ff  <= fmem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         acc_ff       <= '0;
         bias_ff      <= '0;
         cnt_ff       <= '0;
         wval_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         acc_ff       <= acc_in;
         bias_ff      <= bias_in;
         cnt_ff       <= cnt_in;
         wval_ff      <= wval_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff     <= walk_in;
      x_ff        <= x_in;
      func_ff     <= func_in;
      label_ff    <= label_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      pred_neg_ff <= pred_neg_in;
      mis_ff      <= mis_in;
      changed_ff  <= changed_in;
      rsp_pred_ff <= rsp_pred_in;
      rsp_mis_ff  <= rsp_mis_in;
      rsp_chg_ff  <= rsp_chg_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_predicted_class = rsp_pred_ff;
   assign rsp_misclassified   = rsp_mis_ff;
   assign rsp_weights_changed = rsp_chg_ff;
   assign rsp_update_count    = rsp_cnt_ff;

   // The front end's sample tagging must agree with the back end's index.
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (q_item.last == (idx_ff == LAST_IDX)))
      else $error("last-feature tag out of step with feature index");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result word raised outside the emit step");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && idx_ff == '0) |-> (acc_ff == '0))
      else $error("accumulator not cleared at sample start");

   assert property (@(posedge clock) disable iff (reset)
      !reset |=> (cnt_ff >= $past(cnt_ff)))
      else $error("update counter went backwards");

endmodule

`default_nettype wire

>>> src/online_perceptron_trainer_unit.sv
// ----------------------------------------------------------------------------
// Online perceptron trainer unit
// Streams labelled samples one feature per word, predicts the class after
// the last feature and applies perceptron or delta rule updates.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake         Payload
//  req_      in         req_valid/stall   func, feature, label
//  rsp_      out        rsp_valid/stall   predicted_class, misclassified,
//                                         weights_changed, update_count
//
// Each feature passes through a multiply stage and an accumulate stage in
// the back end, overlapped with fetching the next feature from the queue.
// The first feature of a sample is taken from the queue in the idle state,
// and the last adds a decision step and an output step. An update walks the
// weight store with a read-modify-write of each weight and then steps the
// bias. The queue keeps taking words while this runs. Reset is synchronous
// and clears the weights, bias and counter. rsp_stall only holds the result
// register; the back end waits on it solely when a new result is ready and
// the old one has not been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module online_perceptron_trainer_unit #(
   parameter int DIM    = opt_pkg::DIM_DEFAULT,
   parameter int QDEPTH = opt_pkg::QUEUE_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [opt_pkg::FUNC_W-1:0]        req_func,
   input  wire logic signed [opt_pkg::FEAT_W-1:0] req_feature,
   input  wire logic                              req_label,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_predicted_class,
   output logic                                   rsp_misclassified,
   output logic                                   rsp_weights_changed,
   output logic [opt_pkg::COUNT_W-1:0]            rsp_update_count
);
   import opt_pkg::*;

   queue_item_type push_item;
   queue_item_type pop_item;
   logic           q_push;
   logic           q_full;
   logic           q_pop;
   logic           q_empty;

   opt_front #(
      .DIM (DIM)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_feature (req_feature),
      .req_label   (req_label),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (push_item)
   );

   opt_queue #(
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .empty     (q_empty)
   );

   opt_back #(
      .DIM (DIM)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_item              (pop_item),
      .q_empty             (q_empty),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_predicted_class (rsp_predicted_class),
      .rsp_misclassified   (rsp_misclassified),
      .rsp_weights_changed (rsp_weights_changed),
      .rsp_update_count    (rsp_update_count)
   );

endmodule

`default_nettype wire

>>> bench/online_perceptron_trainer_unit_tb.sv
// ----------------------------------------------------------------------------
// Online perceptron trainer unit testbench
// Sends labelled samples one feature word at a time and predicts every
// decision word with its own copy of the weights, bias and update counter.
// Directed samples cover each function code and the feature extremes; a long
// random stream then mixes learnable and noisy samples under bursty sending
// and a changing receiver stall pattern.
// ----------------------------------------------------------------------------
module online_perceptron_trainer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import opt_pkg::*;

   localparam int FEATURES = DIM_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 64;
   localparam int RANDOM_SAMPLES = 112;
   localparam int REPORT_LIMIT = 10;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam longint Q14_ONE = longint'(1) << BIAS_SHIFT;
   localparam longint DELTA_GAIN = 2;
   localparam longint WEIGHT_MAX = 64'sd2147483647;
   localparam longint WEIGHT_MIN = -64'sd2147483648;

   typedef logic [FEATURES-1:0][FEAT_W-1:0] sample_type;

   typedef struct {
      logic               predicted_class;
      logic               misclassified;
      logic               weights_changed;
      logic [COUNT_W-1:0] update_count;
   } decision_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [FUNC_W-1:0]        req_func = FUNC_PREDICT;
   logic signed [FEAT_W-1:0] req_feature = '0;
   logic                     req_label = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_predicted_class;
   logic                     rsp_misclassified;
   logic                     rsp_weights_changed;
   logic [COUNT_W-1:0]       rsp_update_count;

   // Trainer state as the bench sees it.
   logic signed [WEIGHT_W-1:0] weight_model [FEATURES];
   logic signed [WEIGHT_W-1:0] bias_model;
   logic signed [FEAT_W-1:0]   feature_store [FEATURES];
   int                         feature_slot;
   longint                     dot_sum;
   logic [COUNT_W-1:0]         update_total;

   decision_type decision_queue [$];

   int cycle_count = 0;
   int stall_hold = 0;
   int burst_left = 0;
   int fault_count = 0;
   int words_sent = 0;
   int decisions_checked = 0;
   int misses_seen = 0;

   online_perceptron_trainer_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_feature         (req_feature),
      .req_label           (req_label),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_predicted_class (rsp_predicted_class),
      .rsp_misclassified   (rsp_misclassified),
      .rsp_weights_changed (rsp_weights_changed),
      .rsp_update_count    (rsp_update_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("online_perceptron_trainer_unit test failed");
      $finish;
   end

   initial begin
      for (int k = 0; k < FEATURES; k++) begin
         weight_model[k] = '0;
         feature_store[k] = '0;
      end
      bias_model = '0;
      feature_slot = 0;
      dot_sum = 0;
      update_total = '0;
   end

   // The receiver changes its stall habit with bits 10:9 of the cycle count: none,
   // random, long runs, and stall on alternate cycles.
   always @(posedge clock) begin
      if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         case (cycle_count[10:9])
            2'd0: rsp_stall <= 1'b0;
            2'd1: rsp_stall <= ($urandom_range(0, 2) == 0);
            2'd2: begin
               rsp_stall  <= !rsp_stall;
               stall_hold <= $urandom_range(0, 30);
            end
            default: rsp_stall <= !rsp_stall;
         endcase
      end
   end

   function automatic logic signed [WEIGHT_W-1:0] clamp_add(
      input logic signed [WEIGHT_W-1:0] base,
      input longint                     delta
   );
      longint total;
      total = longint'(base) + delta;
      if (total > WEIGHT_MAX) return WEIGHT_MAX[WEIGHT_W-1:0];
      if (total < WEIGHT_MIN) return WEIGHT_MIN[WEIGHT_W-1:0];
      return total[WEIGHT_W-1:0];
   endfunction

   // Folds one accepted feature word into the trainer state and queues the
   // decision word that the last feature of a sample produces.
   task automatic train_step_model(
      input logic [FUNC_W-1:0]        f,
      input logic signed [FEAT_W-1:0] x,
      input logic                     lab
   );
      longint       z;
      longint       y;
      longint       pred;
      longint       gain;
      decision_type d;
      feature_store[feature_slot] = x;
      dot_sum += longint'(weight_model[feature_slot]) * longint'(x);
      if (feature_slot < FEATURES - 1) begin
         feature_slot++;
         return;
      end
      z = dot_sum + longint'(bias_model) * Q14_ONE;
      d.predicted_class = (z < 0);
      d.misclassified = (d.predicted_class != lab);
      d.weights_changed = 1'b0;
      if (d.misclassified && (f == FUNC_PERCEPTRON || f == FUNC_DELTA)) begin
         y = lab ? -1 : 1;
         pred = d.predicted_class ? -1 : 1;
         gain = (f == FUNC_PERCEPTRON) ? y : DELTA_GAIN * (y - pred);
         for (int j = 0; j < FEATURES; j++) begin
            weight_model[j] = clamp_add(weight_model[j], gain * longint'(feature_store[j]));
         end
         bias_model = clamp_add(bias_model, gain * Q14_ONE);
         if (update_total != '1) update_total++;
         d.weights_changed = 1'b1;
      end
      d.update_count = update_total;
      if (d.misclassified) misses_seen++;
      feature_slot = 0;
      dot_sum = 0;
      decision_queue.push_back(d);
   endtask

   task automatic send_word(
      input logic [FUNC_W-1:0]        f,
      input logic signed [FEAT_W-1:0] x,
      input logic                     lab
   );
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         // Now and then a long burst with no gaps at all.
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      req_valid   <= 1'b1;
      req_func    <= f;
      req_feature <= x;
      req_label   <= lab;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      words_sent++;
      train_step_model(f, x, lab);
   endtask

   // Only the function and label given with the last feature count, so the
   // earlier words of a sample carry random ones.
   task automatic send_sample(
      input sample_type        xs,
      input logic [FUNC_W-1:0] last_func,
      input logic              last_label
   );
      for (int k = 0; k < FEATURES - 1; k++) begin
         send_word(FUNC_W'($urandom_range(0, 3)), xs[k], 1'($urandom_range(0, 1)));
      end
      send_word(last_func, xs[FEATURES-1], last_label);
   endtask

   task automatic pause_sender();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (decision_queue.size() != 0) @(posedge clock);
   endtask

   // With zero weights the sum is zero, so the prediction is +1 and a label
   // of -1 is reported as misclassified without any update.
   task automatic test_predict_only();
      sample_type xs;
      xs[0] = 16'h8000; xs[1] = 16'h7fff; xs[2] = 16'h0000; xs[3] = 16'h0001;
      xs[4] = 16'hffff; xs[5] = 16'h4000; xs[6] = 16'hc000; xs[7] = 16'h5555;
      send_sample(xs, FUNC_PREDICT, 1'b1);
   endtask

   task automatic test_unused_func();
      sample_type xs;
      xs[0] = 16'haaaa; xs[1] = 16'h8000; xs[2] = 16'h7fff; xs[3] = 16'h1234;
      xs[4] = 16'hedcb; xs[5] = 16'h0000; xs[6] = 16'h8001; xs[7] = 16'h7ffe;
      send_sample(xs, FUNC_UNUSED, 1'b1);
   endtask

   task automatic test_perceptron_rule();
      sample_type xs;
      xs[0] = 16'h7fff; xs[1] = 16'h8000; xs[2] = 16'h04d2; xs[3] = 16'hffff;
      xs[4] = 16'h0000; xs[5] = 16'h2000; xs[6] = 16'hec78; xs[7] = 16'h7fff;
      send_sample(xs, FUNC_PERCEPTRON, 1'b1);
   endtask

   // The same sample after the perceptron step scores below zero, so a +1
   // label is wrong and the delta rule moves everything by four times y.
   task automatic test_delta_rule();
      sample_type xs;
      xs[0] = 16'h7fff; xs[1] = 16'h8000; xs[2] = 16'h04d2; xs[3] = 16'hffff;
      xs[4] = 16'h0000; xs[5] = 16'h2000; xs[6] = 16'hec78; xs[7] = 16'h7fff;
      send_sample(xs, FUNC_DELTA, 1'b0);
   endtask

   task automatic test_random_stream();
      sample_type        xs;
      logic [FUNC_W-1:0] last_func;
      logic              lab;
      longint            teacher;
      int                style;
      int                pick;
      for (int s = 0; s < RANDOM_SAMPLES; s++) begin
         style = $urandom_range(0, 9);
         teacher = 0;
         for (int k = 0; k < FEATURES; k++) begin
            if (style < 4 || style > 7) begin
               xs[k] = FEAT_W'($urandom_range(0, 65535));
            end else if (style < 6) begin
               case ($urandom_range(0, 4))
                  0: xs[k] = 16'h8000;
                  1: xs[k] = 16'h7fff;
                  2: xs[k] = 16'h0000;
                  3: xs[k] = 16'h0001;
                  default: xs[k] = 16'hffff;
               endcase
            end else begin
               xs[k] = FEAT_W'(int'($urandom_range(0, 1023)) - 512);
            end
            teacher += ((k % 3 == 0) ? -1 : 1) * longint'(signed'(xs[k]));
         end
         // The top styles follow a fixed separating plane, so the weights
         // settle towards it and correct predictions show up too.
         lab = (style > 7) ? (teacher < 0) : 1'($urandom_range(0, 1));
         pick = $urandom_range(0, 19);
         if (pick < 8) last_func = FUNC_PERCEPTRON;
         else if (pick < 15) last_func = FUNC_DELTA;
         else if (pick < 18) last_func = FUNC_PREDICT;
         else last_func = FUNC_UNUSED;
         send_sample(xs, last_func, lab);
         if (s % 37 == 36) pause_sender();
      end
   endtask

   always @(posedge clock) begin
      decision_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (decision_queue.size() == 0) begin
            if (fault_count < REPORT_LIMIT) begin
               $display("%0t: decision word with nothing expected: class %0b miss %0b chg %0b cnt %0d",
                        $realtime, rsp_predicted_class, rsp_misclassified,
                        rsp_weights_changed, rsp_update_count);
            end
            fault_count++;
         end else begin
            want = decision_queue.pop_front();
            decisions_checked++;
            if (rsp_predicted_class !== want.predicted_class ||
                rsp_misclassified !== want.misclassified ||
                rsp_weights_changed !== want.weights_changed ||
                rsp_update_count !== want.update_count) begin
               if (fault_count < REPORT_LIMIT) begin
                  $display("%0t: decision %0d expected class %0b miss %0b chg %0b cnt %0d",
                           $realtime, decisions_checked, want.predicted_class,
                           want.misclassified, want.weights_changed, want.update_count);
                  $display("%0t: decision %0d actual   class %0b miss %0b chg %0b cnt %0d",
                           $realtime, decisions_checked, rsp_predicted_class,
                           rsp_misclassified, rsp_weights_changed, rsp_update_count);
               end
               fault_count++;
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_predict_only();
      pause_sender();
      test_unused_func();
      test_perceptron_rule();
      pause_sender();
      test_delta_rule();
      test_random_stream();
      pause_sender();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (decision_queue.size() != 0) begin
         $display("%0d decision words never arrived", decision_queue.size());
         fault_count += decision_queue.size();
      end
      $display("Sent %0d feature words; checked %0d decisions, %0d misclassified.",
               words_sent, decisions_checked, misses_seen);
      $display("Weight updates applied: %0d; mismatches: %0d.", update_total, fault_count);
      if (fault_count == 0) begin
         $display("online_perceptron_trainer_unit test passed");
      end else begin
         $display("online_perceptron_trainer_unit test failed");
      end
      $finish;
   end

endmodule
